FILE: design/dttd_pkg.sv
// Shared types, constants and helpers for the dictionary text token decoder.
package dttd_pkg;

  localparam int unsigned MaxWordsDef   = 256;
  localparam int unsigned MaxWordLenDef = 32;

  // Load byte that closes the current word
  localparam logic [7:0] CloseByte = 8'h40;

  // Decode offsets above the word count
  localparam logic [7:0] OffNewline  = 8'd0;
  localparam logic [7:0] OffLetterLo = 8'd1;
  localparam logic [7:0] OffLetterHi = 8'd26;
  localparam logic [7:0] OffPeriod   = 8'd27;
  localparam logic [7:0] OffQuestion = 8'd28;
  localparam logic [7:0] OffBang     = 8'd29;
  localparam logic [7:0] OffComma    = 8'd30;
  localparam logic [7:0] OffColon    = 8'd31;
  localparam logic [7:0] OffSpace    = 8'd32;
  localparam logic [7:0] OffApos     = 8'd33;
  localparam logic [7:0] OffCap      = 8'd34;
  localparam logic [7:0] OffParen    = 8'd35;
  localparam logic [7:0] OffQuote    = 8'd36;

  localparam logic [7:0] UpperBase = 8'd64;
  localparam logic [7:0] LowerBase = 8'd96;

  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChPeriod   = 8'h2E;
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChBang     = 8'h21;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChApos     = 8'h27;
  localparam logic [7:0] ChOpen     = 8'h28;
  localparam logic [7:0] ChClose    = 8'h29;
  localparam logic [7:0] ChQuote    = 8'h22;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_WORD,
    ST_EMIT1,
    ST_EMIT2
  } st_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       bad;
    logic       last;
  } out_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

FILE: design/dttd_store.sv
// Word character memory and word length memory, both with registered reads.
module dttd_store import dttd_pkg::*; #(
  parameter int unsigned MaxWords   = MaxWordsDef,
  parameter int unsigned MaxWordLen = MaxWordLenDef,
  localparam int unsigned Depth     = MaxWords * MaxWordLen,
  localparam int unsigned AddrW     = $clog2(Depth),
  localparam int unsigned IdxW      = $clog2(MaxWords),
  localparam int unsigned PosW      = $clog2(MaxWordLen)
) (
  input  logic             clk_i,
  input  logic             ch_we_i,
  input  logic [AddrW-1:0] ch_waddr_i,
  input  logic [7:0]       ch_wdata_i,
  input  logic             ch_re_i,
  input  logic [AddrW-1:0] ch_raddr_i,
  output logic [7:0]       ch_rdata_o,
  input  logic             len_we_i,
  input  logic [IdxW-1:0]  len_waddr_i,
  input  logic [PosW-1:0]  len_wdata_i,
  input  logic             len_re_i,
  input  logic [IdxW-1:0]  len_raddr_i,
  output logic [PosW-1:0]  len_rdata_o
);

  logic [7:0]      char_mem [Depth];
  logic [PosW-1:0] len_mem  [MaxWords];
  logic [7:0]      ch_rdata_q;
  logic [PosW-1:0] len_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ch_we_i) begin
      char_mem[ch_waddr_i] <= ch_wdata_i;
    end
    if (ch_re_i) begin
      ch_rdata_q <= char_mem[ch_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[len_waddr_i] <= len_wdata_i;
    end
    if (len_re_i) begin
      len_rdata_q <= len_mem[len_raddr_i];
    end
  end

  assign ch_rdata_o  = ch_rdata_q;
  assign len_rdata_o = len_rdata_q;

endmodule

FILE: design/dttd_seq.sv
// Sequencer: load bookkeeping, decode FSM, word streaming and output register.
module dttd_seq import dttd_pkg::*; #(
  parameter int unsigned MaxWords   = MaxWordsDef,
  parameter int unsigned MaxWordLen = MaxWordLenDef,
  localparam int unsigned AddrW     = $clog2(MaxWords * MaxWordLen),
  localparam int unsigned IdxW      = $clog2(MaxWords),
  localparam int unsigned PosW      = $clog2(MaxWordLen),
  localparam int unsigned CntW      = $clog2(MaxWords + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_o,
  output logic             ch_we_o,
  output logic [AddrW-1:0] ch_waddr_o,
  output logic [7:0]       ch_wdata_o,
  output logic             ch_re_o,
  output logic [AddrW-1:0] ch_raddr_o,
  input  logic [7:0]       ch_rdata_i,
  output logic             len_we_o,
  output logic [IdxW-1:0]  len_waddr_o,
  output logic [PosW-1:0]  len_wdata_o,
  output logic             len_re_o,
  output logic [IdxW-1:0]  len_raddr_o,
  input  logic [PosW-1:0]  len_rdata_i
);

  localparam logic [AddrW-1:0] Stride  = AddrW'(MaxWordLen);
  localparam logic [CntW-1:0]  CntFull = CntW'(MaxWords);
  localparam logic [PosW-1:0]  PosMax  = PosW'(MaxWordLen - 1);

  st_e             state_q, state_d;
  logic [CntW-1:0] wc_q, wc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            cap_q, cap_d;
  logic            paren_q, paren_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic [AddrW-1:0] base_q, base_d;
  logic [PosW-1:0]  len_q, len_d;
  logic [PosW-1:0]  i_q, i_d;
  logic [7:0]       ch1_q, ch1_d;
  logic             two_q, two_d;
  logic             bad_q, bad_d;
  logic             capf_q, capf_d;

  logic            in_fire;
  logic            can_load;
  logic            push;
  out_t            push_data;
  logic [7:0]      off;
  logic            is_word;
  logic [PosW-1:0] next_i;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_q || !out_stall_i;
  assign off        = in_i.value - 8'(wc_q);
  assign is_word    = {1'b0, in_i.value} < 9'(wc_q);
  assign next_i     = i_q + PosW'(1);

  always_comb begin
    state_d   = state_q;
    wc_d      = wc_q;
    pos_d     = pos_q;
    cap_d     = cap_q;
    paren_d   = paren_q;
    base_d    = base_q;
    len_d     = len_q;
    i_d       = i_q;
    ch1_d     = ch1_q;
    two_d     = two_q;
    bad_d     = bad_q;
    capf_d    = capf_q;
    push      = 1'b0;
    push_data = '0;

    ch_we_o     = 1'b0;
    ch_waddr_o  = AddrW'(wc_q[IdxW-1:0]) * Stride + AddrW'(pos_q);
    ch_wdata_o  = in_i.value;
    ch_re_o     = 1'b0;
    ch_raddr_o  = base_q;
    len_we_o    = 1'b0;
    len_waddr_o = wc_q[IdxW-1:0];
    len_wdata_o = pos_q;
    len_re_o    = 1'b0;
    len_raddr_o = in_i.value[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_i.kind) begin
            // loads are dropped once the store is full
            if (wc_q != CntFull) begin
              if (in_i.value == CloseByte) begin
                len_we_o = 1'b1;
                wc_d     = wc_q + CntW'(1);
                pos_d    = '0;
              end else if (pos_q != PosMax) begin
                ch_we_o = 1'b1;
                pos_d   = pos_q + PosW'(1);
              end
            end
          end else if (is_word) begin
            len_re_o = 1'b1;
            base_d   = AddrW'(in_i.value[IdxW-1:0]) * Stride;
            capf_d   = cap_q;
            cap_d    = 1'b0;
            state_d  = ST_LEN;
          end else begin
            bad_d   = 1'b0;
            two_d   = 1'b0;
            ch1_d   = off;
            state_d = ST_EMIT1;
            unique case (off) inside
              OffNewline: ch1_d = ChNewline;
              [OffLetterLo:OffLetterHi]: begin
                ch1_d = off + (cap_q ? UpperBase : LowerBase);
                cap_d = 1'b0;
              end
              OffPeriod: begin
                ch1_d = ChPeriod;
                two_d = 1'b1;
                cap_d = 1'b1;
              end
              OffQuestion: begin
                ch1_d = ChQuestion;
                two_d = 1'b1;
                cap_d = 1'b1;
              end
              OffBang: begin
                ch1_d = ChBang;
                two_d = 1'b1;
                cap_d = 1'b1;
              end
              OffComma: begin
                ch1_d = ChComma;
                two_d = 1'b1;
              end
              OffColon: begin
                ch1_d = ChColon;
                two_d = 1'b1;
              end
              OffSpace: ch1_d = ChSpace;
              OffApos:  ch1_d = ChApos;
              OffCap: begin
                cap_d   = 1'b1;
                state_d = ST_IDLE;
              end
              OffParen: begin
                ch1_d   = paren_q ? ChClose : ChOpen;
                paren_d = !paren_q;
              end
              OffQuote: ch1_d = ChQuote;
              default:  bad_d = 1'b1;
            endcase
          end
        end
      end
      ST_LEN: begin
        len_d = len_rdata_i;
        i_d   = '0;
        if (len_rdata_i == '0) begin
          state_d = ST_IDLE;
        end else begin
          ch_re_o = 1'b1;
          state_d = ST_WORD;
        end
      end
      ST_WORD: begin
        // read data holds while the output is stalled, no read is issued then
        if (can_load) begin
          push           = 1'b1;
          push_data.ch   = (i_q == '0 && capf_q) ? ch_rdata_i : to_lower(ch_rdata_i);
          push_data.bad  = 1'b0;
          push_data.last = (next_i == len_q);
          if (next_i == len_q) begin
            state_d = ST_IDLE;
          end else begin
            ch_re_o    = 1'b1;
            ch_raddr_o = base_q + AddrW'(next_i);
            i_d        = next_i;
          end
        end
      end
      ST_EMIT1: begin
        if (can_load) begin
          push           = 1'b1;
          push_data.ch   = ch1_q;
          push_data.bad  = bad_q;
          push_data.last = !two_q;
          state_d        = two_q ? ST_EMIT2 : ST_IDLE;
        end
      end
      ST_EMIT2: begin
        if (can_load) begin
          push           = 1'b1;
          push_data.ch   = ChSpace;
          push_data.bad  = 1'b0;
          push_data.last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wc_q        <= '0;
      pos_q       <= '0;
      cap_q       <= 1'b0;
      paren_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wc_q        <= wc_d;
      pos_q       <= pos_d;
      cap_q       <= cap_d;
      paren_q     <= paren_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    base_q <= base_d;
    len_q  <= len_d;
    i_q    <= i_d;
    ch1_q  <= ch1_d;
    two_q  <= two_d;
    bad_q  <= bad_d;
    capf_q <= capf_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: design/dictionary_text_token_decoder.sv
// Dictionary text token decoder: top level.
//
// Input channel (in_valid_i / in_stall_o / in_i) takes one byte per transfer.
// kind = 0 loads a dictionary byte; 0x40 closes the current word. kind = 1
// decodes a text byte into zero or more characters on the output channel
// (out_valid_o / out_stall_i / out_o); last marks the final character of the
// byte, bad marks an unknown code with the offset in ch.
// Items are worked one at a time and in_stall_o is high while one is busy.
// A load is written in the idle state. A word reference first reads the
// length memory, then issues the first character read, then streams one
// character per cycle from the character memory while the output is not
// stalled. Any other single-character code, an unknown one included, passes
// through ST_EMIT1, a two-character punctuation through ST_EMIT1 and
// ST_EMIT2, and a capitalize request emits nothing. A stalled receiver holds it.
// Results pass through one output register, so the first character appears
// in the cycle after it is formed and the output holds while stalled.
// Reset clears the word count, load position, capitalize flag, parenthesis
// toggle and output valid; the memories keep their contents and are defined
// only once written.
module dictionary_text_token_decoder import dttd_pkg::*; #(
  parameter int unsigned MaxWords   = MaxWordsDef,
  parameter int unsigned MaxWordLen = MaxWordLenDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int unsigned AddrW = $clog2(MaxWords * MaxWordLen);
  localparam int unsigned IdxW  = $clog2(MaxWords);
  localparam int unsigned PosW  = $clog2(MaxWordLen);

  logic             ch_we;
  logic [AddrW-1:0] ch_waddr;
  logic [7:0]       ch_wdata;
  logic             ch_re;
  logic [AddrW-1:0] ch_raddr;
  logic [7:0]       ch_rdata;
  logic             len_we;
  logic [IdxW-1:0]  len_waddr;
  logic [PosW-1:0]  len_wdata;
  logic             len_re;
  logic [IdxW-1:0]  len_raddr;
  logic [PosW-1:0]  len_rdata;

  dttd_seq #(
    .MaxWords  (MaxWords),
    .MaxWordLen(MaxWordLen)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .ch_we_o    (ch_we),
    .ch_waddr_o (ch_waddr),
    .ch_wdata_o (ch_wdata),
    .ch_re_o    (ch_re),
    .ch_raddr_o (ch_raddr),
    .ch_rdata_i (ch_rdata),
    .len_we_o   (len_we),
    .len_waddr_o(len_waddr),
    .len_wdata_o(len_wdata),
    .len_re_o   (len_re),
    .len_raddr_o(len_raddr),
    .len_rdata_i(len_rdata)
  );

  dttd_store #(
    .MaxWords  (MaxWords),
    .MaxWordLen(MaxWordLen)
  ) u_store (
    .clk_i      (clk_i),
    .ch_we_i    (ch_we),
    .ch_waddr_i (ch_waddr),
    .ch_wdata_i (ch_wdata),
    .ch_re_i    (ch_re),
    .ch_raddr_i (ch_raddr),
    .ch_rdata_o (ch_rdata),
    .len_we_i   (len_we),
    .len_waddr_i(len_waddr),
    .len_wdata_i(len_wdata),
    .len_re_i   (len_re),
    .len_raddr_i(len_raddr),
    .len_rdata_o(len_rdata)
  );

endmodule

FILE: design/dttd_checker.sv
// Port-level checks for the dictionary text token decoder, bound to the top level.
module dttd_checker import dttd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_o
);

  // an error result is always the only result of its item
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.bad |-> out_o.last)
    else $error("error result without last");

  // error results only carry offsets beyond the known codes
  a_bad_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.bad |-> out_o.ch > OffQuote)
    else $error("error result with a known offset");

  // a load transfer leaves the input channel unstalled
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_i.kind |=> !in_stall_o)
    else $error("stall after a load transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

endmodule

bind dictionary_text_token_decoder dttd_checker u_dttd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_i       (in_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_o      (out_o)
);

FILE: dv/dictionary_text_token_decoder_tb.sv
// Self-checking testbench for the dictionary text token decoder.
`timescale 1ns / 1ps

module dictionary_text_token_decoder_tb;
  import dttd_pkg::*;

  localparam int unsigned MaxWords   = MaxWordsDef;
  localparam int unsigned MaxWordLen = MaxWordLenDef;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned TailCycles = 200;

  localparam logic KindLoad = 1'b0;
  localparam logic KindText = 1'b1;

  localparam logic [7:0] BadOffLo = 8'd37;
  localparam logic [7:0] BadOffHi = 8'd255;

  // one directed transfer; ch/bad only meaningful when typed is set
  typedef struct packed {
    logic       typed;
    logic       kind;
    logic [7:0] value;
    logic [7:0] ch;
    logic       bad;
  } row_t;

  localparam int NumRows = 28;
  localparam row_t DirRows [NumRows] = '{
    '{1'b1, KindText, OffNewline,  ChNewline,               1'b0},
    '{1'b1, KindText, BadOffLo,    BadOffLo,                1'b1},
    '{1'b1, KindText, BadOffHi,    BadOffHi,                1'b1},
    '{1'b1, KindText, OffLetterLo, LowerBase + OffLetterLo, 1'b0},
    '{1'b1, KindText, OffLetterHi, LowerBase + OffLetterHi, 1'b0},
    '{1'b1, KindText, OffQuote,    ChQuote,                 1'b0},
    '{1'b0, KindText, OffCap,      8'h00, 1'b0},
    '{1'b0, KindText, OffLetterLo, 8'h00, 1'b0},
    '{1'b0, KindText, OffPeriod,   8'h00, 1'b0},
    '{1'b0, KindText, OffQuestion, 8'h00, 1'b0},
    '{1'b0, KindText, OffBang,     8'h00, 1'b0},
    '{1'b0, KindText, OffComma,    8'h00, 1'b0},
    '{1'b0, KindText, OffColon,    8'h00, 1'b0},
    '{1'b0, KindText, OffSpace,    8'h00, 1'b0},
    '{1'b0, KindText, OffApos,     8'h00, 1'b0},
    '{1'b0, KindText, OffParen,    8'h00, 1'b0},
    '{1'b0, KindText, OffParen,    8'h00, 1'b0},
    // word 0: uppercase, a zero byte and a non-letter; word 1 is empty
    '{1'b0, KindLoad, 8'h51,       8'h00, 1'b0},
    '{1'b0, KindLoad, 8'h00,       8'h00, 1'b0},
    '{1'b0, KindLoad, 8'h5B,       8'h00, 1'b0},
    '{1'b0, KindLoad, CloseByte,   8'h00, 1'b0},
    '{1'b0, KindLoad, CloseByte,   8'h00, 1'b0},
    // two words loaded, so codes now sit two above their offsets
    '{1'b0, KindText, OffCap + 8'd2, 8'h00, 1'b0},
    '{1'b0, KindText, 8'd1,        8'h00, 1'b0},
    '{1'b0, KindText, 8'd0,        8'h00, 1'b0},
    '{1'b0, KindText, OffCap + 8'd2, 8'h00, 1'b0},
    '{1'b0, KindText, 8'd0,        8'h00, 1'b0},
    '{1'b0, KindText, 8'd2,        8'h00, 1'b0}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_item     = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_item;

  // typed expectation travels with the payload
  logic row_typed = 1'b0;
  out_t row_want  = '0;

  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;

  dictionary_text_token_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_item)
  );

  always #5 clk_i = ~clk_i;

  // decoder state as seen by the predictor
  logic [7:0] dict_chars [MaxWords*MaxWordLen];
  logic [5:0] dict_len [MaxWords];
  logic [8:0] n_words      = '0;
  logic [5:0] load_pos     = '0;
  logic       cap_pending  = 1'b0;
  logic       paren_closes = 1'b0;
  out_t       text_q[$];

  int unsigned n_err   = 0;
  int unsigned n_text  = 0;
  int unsigned n_chars = 0;
  int unsigned n_bad   = 0;

  function automatic void push_char(input logic [7:0] c, input logic b);
    out_t r;
    r.ch   = c;
    r.bad  = b;
    r.last = 1'b0;
    text_q.push_back(r);
  endfunction

  function automatic void expand_byte(input in_t it);
    logic [7:0] off;
    logic [7:0] c;
    int unsigned i;
    int unsigned n0;
    out_t r;
    n0 = text_q.size();
    if (it.kind == KindLoad) begin
      if (n_words < MaxWords) begin
        if (it.value == CloseByte) begin
          dict_len[n_words] = load_pos;
          n_words = n_words + 1'b1;
          load_pos = '0;
        end else if (load_pos < MaxWordLen - 1) begin
          dict_chars[n_words*MaxWordLen + load_pos] = it.value;
          load_pos = load_pos + 1'b1;
        end
      end
      return;
    end
    if ({1'b0, it.value} < n_words) begin
      for (i = 0; i < dict_len[it.value]; i++) begin
        c = dict_chars[it.value*MaxWordLen + i];
        // first character keeps its case when a capital is pending
        if (!(i == 0 && cap_pending) && c >= 8'h41 && c <= 8'h5A) begin
          c = c + 8'd32;
        end
        push_char(c, 1'b0);
      end
      cap_pending = 1'b0;
    end else begin
      off = it.value - n_words[7:0];
      if (off == OffNewline) begin
        push_char(ChNewline, 1'b0);
      end else if (off <= OffLetterHi) begin
        push_char(off + (cap_pending ? UpperBase : LowerBase), 1'b0);
        cap_pending = 1'b0;
      end else begin
        case (off)
          OffPeriod: begin
            push_char(ChPeriod, 1'b0);
            push_char(ChSpace, 1'b0);
            cap_pending = 1'b1;
          end
          OffQuestion: begin
            push_char(ChQuestion, 1'b0);
            push_char(ChSpace, 1'b0);
            cap_pending = 1'b1;
          end
          OffBang: begin
            push_char(ChBang, 1'b0);
            push_char(ChSpace, 1'b0);
            cap_pending = 1'b1;
          end
          OffComma: begin
            push_char(ChComma, 1'b0);
            push_char(ChSpace, 1'b0);
          end
          OffColon: begin
            push_char(ChColon, 1'b0);
            push_char(ChSpace, 1'b0);
          end
          OffSpace: push_char(ChSpace, 1'b0);
          OffApos:  push_char(ChApos, 1'b0);
          OffCap:   cap_pending = 1'b1;
          OffParen: begin
            push_char(paren_closes ? ChClose : ChOpen, 1'b0);
            paren_closes = ~paren_closes;
          end
          OffQuote: push_char(ChQuote, 1'b0);
          default:  push_char(off, 1'b1);
        endcase
      end
    end
    if (text_q.size() > n0) begin
      r = text_q.pop_back();
      r.last = 1'b1;
      text_q.push_back(r);
    end
  endfunction

  // predicts on input transfers, checks output transfers, drives the receiver
  always @(posedge clk_i) begin : scoreboard
    int unsigned n0;
    int unsigned quiet_cycles;
    out_t want;
    logic fail;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        n0 = text_q.size();
        expand_byte(in_item);
        if (in_item.kind == KindText) n_text++;
        if (row_typed) begin
          while (text_q.size() > n0) void'(text_q.pop_back());
          text_q.push_back(row_want);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (text_q.size() == 0) begin
          $display("%0t: unexpected result ch=%h bad=%b last=%b", $time,
                   out_item.ch, out_item.bad, out_item.last);
          n_err++;
        end else begin
          want = text_q.pop_front();
          fail = 1'b0;
          if (out_item.ch !== want.ch) begin
            $display("%0t: ch mismatch: expected %h, got %h", $time, want.ch, out_item.ch);
            fail = 1'b1;
          end
          if (out_item.bad !== want.bad) begin
            $display("%0t: bad mismatch: expected %b, got %b", $time, want.bad, out_item.bad);
            fail = 1'b1;
          end
          if (out_item.last !== want.last) begin
            $display("%0t: last mismatch: expected %b, got %b", $time,
                     want.last, out_item.last);
            fail = 1'b1;
          end
          if (fail) n_err++;
          n_chars++;
          if (want.bad) n_bad++;
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, text_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
    out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
  end

  // stimulus-side view of the store, so the generator can aim at words and offsets
  int unsigned gen_words = 0;
  int unsigned n_items   = 0;

  task automatic send_item(input in_t it, input logic typed, input out_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item    <= it;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk_i); while (in_stall_o);
    if (it.kind == KindLoad && gen_words >= MaxWords) begin
      // store full: the block ignores this one
    end else begin
      n_items++;
      if (it.kind == KindLoad && it.value == CloseByte) gen_words++;
    end
  endtask

  task automatic load_word(input int unsigned len);
    in_t it;
    it.kind = KindLoad;
    repeat (len) begin
      case ($urandom_range(2))
        0:       it.value = 8'h41 + 8'($urandom_range(25));
        1:       it.value = 8'h61 + 8'($urandom_range(25));
        default: it.value = 8'($urandom_range(255));
      endcase
      if (it.value == CloseByte) it.value = 8'h00;
      send_item(it, 1'b0, '0);
    end
    it.value = CloseByte;
    send_item(it, 1'b0, '0);
  endtask

  task automatic text_burst(input int unsigned n);
    int unsigned sel;
    int unsigned span;
    in_t it;
    it.kind = KindText;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 45 && gen_words != 0) begin
        it.value = 8'($urandom_range(gen_words - 1));
      end else if (sel < 88 && gen_words <= 255) begin
        span = 255 - gen_words;
        if (span > OffQuote) span = OffQuote;
        it.value = 8'(gen_words + $urandom_range(span));
      end else if (sel < 95 && gen_words + BadOffLo <= 255) begin
        it.value = 8'($urandom_range(255, gen_words + BadOffLo));
      end else begin
        it.value = 8'($urandom_range(255));
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    // let the scoreboard take the last transfer before looking at the queue
    @(posedge clk_i);
    while (text_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned r;
    int unsigned sel;
    int unsigned len;
    int unsigned start;
    in_t it;
    out_t want;

    snd_idle_pct  = 25;
    rcv_stall_pct = 53;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < NumRows; r++) begin
      it.kind   = DirRows[r].kind;
      it.value  = DirRows[r].value;
      want.ch   = DirRows[r].ch;
      want.bad  = DirRows[r].bad;
      want.last = 1'b1;
      send_item(it, DirRows[r].typed, want);
    end

    for (ph = 0; ph < 3; ph++) begin
      snd_idle_pct  = (ph == 0) ? 25 : (ph == 1) ? 53 : 0;
      rcv_stall_pct = (ph == 0) ? 53 : (ph == 1) ? 25 : 0;
      start = n_items;
      while (n_items - start < 90) begin
        sel = $urandom_range(99);
        if (sel < 30) begin
          sel = $urandom_range(99);
          len = (sel < 35) ? $urandom_range(2) :
                (sel < 80) ? $urandom_range(8, 3) :
                (sel < 92) ? $urandom_range(31, 9) : $urandom_range(40, 32);
          load_word(len);
        end else if (sel < 85) begin
          text_burst($urandom_range(6, 1));
        end else begin
          it = in_t'($urandom_range(511));
          send_item(it, 1'b0, '0);
        end
      end
      if (ph == 2) begin
        // fill the store with short words, decoding a burst every 24 words
        while (gen_words < MaxWords) begin
          load_word(($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0);
          if (gen_words % 24 == 0) text_burst(3);
        end
        it.kind = KindLoad;
        it.value = CloseByte;
        send_item(it, 1'b0, '0);
        it.value = 8'($urandom_range(255));
        send_item(it, 1'b0, '0);
        text_burst(40);
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    n_err += text_q.size();

    $display("Sent %0d items (%0d text bytes), checked %0d characters (%0d bad codes).",
             n_items, n_text, n_chars, n_bad);
    $display("Dictionary reached %0d words under sender/receiver stall mixes.", n_words);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/dttd_pkg.sv
design/dttd_store.sv
design/dttd_seq.sv
design/dictionary_text_token_decoder.sv
design/dttd_checker.sv
dv/dictionary_text_token_decoder_tb.sv
